>>> hdl/rrba_pkg.sv
// Shared constants, types and helpers for the round-robin block averager.
`timescale 1ns / 1ps

package rrba_pkg;

  // Channel and data geometry
  localparam int NUM_CHANNELS = 4;
  localparam int CH_BITS      = $clog2(NUM_CHANNELS);
  localparam int SAMPLE_BITS  = 10;
  localparam int LEN_BITS     = 8;
  localparam int SUM_BITS     = SAMPLE_BITS + LEN_BITS;
  localparam int DIV_STEPS    = SUM_BITS;
  localparam int STEP_BITS    = $clog2(DIV_STEPS);

  // Stream beat layout
  localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS     = 1 + CH_BITS + SAMPLE_BITS + CH_BITS;
  localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // Result field positions inside m_axis_tdata
  localparam int POS_VALID = 0;
  localparam int POS_MCH   = POS_VALID + 1;
  localparam int POS_MEAN  = POS_MCH + CH_BITS;
  localparam int POS_NEXT  = POS_MEAN + SAMPLE_BITS;

  localparam logic [LEN_BITS-1:0]    LEN_RESET  = LEN_BITS'(16);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  typedef logic [CH_BITS-1:0]     ch_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [LEN_BITS-1:0]    len_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  // Divider handshake
  typedef struct packed {
    logic start;
    sum_t dividend;
    len_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    sum_t quotient;
  } div_rsp_t;

  // Step the round-robin pointer
  function automatic ch_t next_ch(input ch_t ch);
    if (ch == ch_t'(NUM_CHANNELS - 1)) begin
      next_ch = '0;
    end else begin
      next_ch = ch + ch_t'(1);
    end
  endfunction

endpackage

>>> hdl/round_robin_block_averager.sv
// Top level of the round-robin block averager: channel state, control and stream ports.
`timescale 1ns / 1ps

// Takes one 10-bit sample per input beat for the channel currently selected, channels
// served in turn 0..3. Each channel accumulates samples until its block length
// (registers 0..3, reset 16, zero acts as one) is reached, then reports the truncated
// mean, saturated at 1023, and restarts its block. Every input beat gives exactly one
// output beat carrying the next channel to select and, when a block closed, the mean
// and its channel. A beat that does not close a block goes IDLE, OUT, IDLE before the
// next accept; one that closes a block first waits in DIV for the bit-serial divider,
// one quotient bit per cycle over the 18-bit sum. A finished beat waits in the output
// register, so input is taken again while it is unread; the next result then waits.
module round_robin_block_averager (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration
  input  logic                              cfg_we_i,
  input  logic [rrba_pkg::CH_BITS-1:0]      cfg_idx_i,
  input  logic [rrba_pkg::LEN_BITS-1:0]     cfg_data_i,
  // Sample stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rrba_pkg::S_TDATA_BITS-1:0] s_axis_tdata,  // [9:0] sample
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rrba_pkg::M_TDATA_BITS-1:0] m_axis_tdata   // mean_valid, mean_channel,
                                                           // mean, next_channel
);

  rrba_pkg::state_e state_q, state_d;
  rrba_pkg::ch_t    ch_q, ch_d;
  rrba_pkg::sum_t   sums_q   [rrba_pkg::NUM_CHANNELS];
  rrba_pkg::len_t   counts_q [rrba_pkg::NUM_CHANNELS];
  rrba_pkg::len_t   len_q    [rrba_pkg::NUM_CHANNELS];

  // Pending result
  logic             res_valid_q, res_valid_d;
  rrba_pkg::ch_t    res_ch_q, res_ch_d;
  rrba_pkg::sample_t res_mean_q, res_mean_d;

  // Output register
  logic                              out_valid_q, out_valid_d;
  logic [rrba_pkg::M_TDATA_BITS-1:0] out_data_q, out_data_d;

  rrba_pkg::div_req_t div_req;
  rrba_pkg::div_rsp_t div_rsp;

  logic              accept;
  rrba_pkg::sample_t smp;
  rrba_pkg::len_t    len_eff;
  rrba_pkg::sum_t    sum_new;
  rrba_pkg::len_t    cnt_new;
  logic              closes;
  logic              out_free;
  rrba_pkg::sample_t mean_sat;

  assign s_axis_tready = (state_q == rrba_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign smp           = s_axis_tdata[rrba_pkg::SAMPLE_BITS-1:0];

  // Accumulate the selected channel and check for block close
  always_comb begin
    len_eff = (len_q[ch_q] == '0) ? rrba_pkg::len_t'(1) : len_q[ch_q];
    sum_new = sums_q[ch_q] + rrba_pkg::sum_t'(smp);
    cnt_new = counts_q[ch_q] + rrba_pkg::len_t'(1);
    closes  = (cnt_new >= len_eff);
  end

  // Saturate the quotient to the sample range
  assign mean_sat = (|div_rsp.quotient[rrba_pkg::SUM_BITS-1:rrba_pkg::SAMPLE_BITS]) ?
                    rrba_pkg::SAMPLE_MAX : div_rsp.quotient[rrba_pkg::SAMPLE_BITS-1:0];

  assign div_req.start    = accept && closes;
  assign div_req.dividend = sum_new;
  assign div_req.divisor  = len_eff;

  rrba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Sequence: accept, optional divide, hand over to the output register
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    res_valid_d = res_valid_q;
    res_ch_d    = res_ch_q;
    res_mean_d  = res_mean_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      rrba_pkg::ST_IDLE: begin
        if (accept) begin
          ch_d        = rrba_pkg::next_ch(ch_q);
          res_valid_d = closes;
          res_ch_d    = closes ? ch_q : '0;
          res_mean_d  = '0;
          state_d     = closes ? rrba_pkg::ST_DIV : rrba_pkg::ST_OUT;
        end
      end
      rrba_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          res_mean_d = mean_sat;
          state_d    = rrba_pkg::ST_OUT;
        end
      end
      rrba_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '0;
          out_data_d[rrba_pkg::POS_VALID]                              = res_valid_q;
          out_data_d[rrba_pkg::POS_MCH +: rrba_pkg::CH_BITS]           = res_ch_q;
          out_data_d[rrba_pkg::POS_MEAN +: rrba_pkg::SAMPLE_BITS]      = res_mean_q;
          out_data_d[rrba_pkg::POS_NEXT +: rrba_pkg::CH_BITS]          = ch_q;
          state_d     = rrba_pkg::ST_IDLE;
        end
      end
      default: state_d = rrba_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrba_pkg::ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Per-channel sums, counts and block lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rrba_pkg::NUM_CHANNELS; i++) begin
        sums_q[i]   <= '0;
        counts_q[i] <= '0;
        len_q[i]    <= rrba_pkg::LEN_RESET;
      end
    end else begin
      if (accept) begin
        sums_q[ch_q]   <= closes ? '0 : sum_new;
        counts_q[ch_q] <= closes ? '0 : cnt_new;
      end
      if (cfg_we_i) begin
        len_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_valid_q <= res_valid_d;
    res_ch_q    <= res_ch_d;
    res_mean_q  <= res_mean_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Divider finishes only while the controller waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == rrba_pkg::ST_DIV)
    else $error("divider done outside divide state");

  // A beat without a closed block carries no mean and no channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[rrba_pkg::POS_VALID]) |->
    (m_axis_tdata[rrba_pkg::POS_NEXT-1:rrba_pkg::POS_MCH] == '0))
    else $error("mean fields set on a beat without a closed block");

  // Next channel follows the closed channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[rrba_pkg::POS_VALID]) |->
    (m_axis_tdata[rrba_pkg::POS_NEXT +: rrba_pkg::CH_BITS] ==
     rrba_pkg::next_ch(m_axis_tdata[rrba_pkg::POS_MCH +: rrba_pkg::CH_BITS])))
    else $error("next channel does not follow the closed channel");

  // Controller state stays one-hot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state not one-hot");

endmodule

>>> hdl/rrba_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module rrba_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrba_pkg::div_req_t req_i,
  output rrba_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [rrba_pkg::STEP_BITS-1:0] step_q, step_d;
  rrba_pkg::sum_t                quo_q, quo_d;
  rrba_pkg::len_t                rem_q, rem_d;
  rrba_pkg::len_t                dvs_q, dvs_d;

  logic [rrba_pkg::LEN_BITS:0]   trial;
  logic [rrba_pkg::LEN_BITS:0]   diff;
  logic                          fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem_q, quo_q[rrba_pkg::SUM_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (busy_q) begin
      quo_d  = {quo_q[rrba_pkg::SUM_BITS-2:0], fits};
      rem_d  = fits ? diff[rrba_pkg::LEN_BITS-1:0] : trial[rrba_pkg::LEN_BITS-1:0];
      step_d = step_q + rrba_pkg::STEP_BITS'(1);
      if (step_q == rrba_pkg::STEP_BITS'(rrba_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath holds no reset
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> dv/tb.sv
// Self-checking testbench for the round-robin block averager.
`timescale 1ns / 1ps

module tb;

  localparam int NUM_PHASES      = 10;
  localparam int SAMPLES_PER_PH  = 120;
  localparam int HOLD_AFTER      = 300;   // results seen before the long output stall
  localparam int HOLD_CYCLES     = 400;
  localparam int QUIET_LIMIT     = 3000;  // cycles with no handshake and no register write
  localparam int DRAIN_CYCLES    = 40;
  localparam int MAX_PRINTS      = 40;

  // Register indexes
  localparam rrba_pkg::ch_t REG_LEN_CH0 = rrba_pkg::ch_t'(0);
  localparam rrba_pkg::ch_t REG_LEN_CH1 = rrba_pkg::ch_t'(1);
  localparam rrba_pkg::ch_t REG_LEN_CH2 = rrba_pkg::ch_t'(2);
  localparam rrba_pkg::ch_t REG_LEN_CH3 = rrba_pkg::ch_t'(3);

  typedef struct packed {
    logic              valid;
    rrba_pkg::ch_t     chan;
    rrba_pkg::sample_t mean;
    rrba_pkg::ch_t     next;
  } mean_beat_t;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    rrba_pkg::ch_t     reg_idx;
    rrba_pkg::len_t    len_val;
    rrba_pkg::sample_t smp;
    logic              typed;
    mean_beat_t        exp;
  } dir_row_t;

  localparam int NUM_DIR = 25;

  // Directed rows; hand-typed expectations where the answer is obvious
  dir_row_t dir_rows [NUM_DIR] = '{
    '{ROW_SAMPLE, '0, '0, 10'd0, 1'b1, '{1'b0, 2'd0, 10'd0, 2'd1}},
    '{ROW_CFG, REG_LEN_CH0, 8'd1, '0, 1'b0, '0},
    '{ROW_CFG, REG_LEN_CH1, 8'd0, '0, 1'b0, '0},
    '{ROW_CFG, REG_LEN_CH2, 8'd255, '0, 1'b0, '0},
    '{ROW_CFG, REG_LEN_CH3, 8'd2, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b1, '{1'b1, 2'd1, 10'd1023, 2'd2}},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b1, '{1'b0, 2'd0, 10'd0, 2'd3}},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b1, '{1'b0, 2'd0, 10'd0, 2'd0}},
    '{ROW_SAMPLE, '0, '0, 10'd0, 1'b1, '{1'b1, 2'd0, 10'd0, 2'd1}},
    '{ROW_SAMPLE, '0, '0, 10'd0, 1'b1, '{1'b1, 2'd1, 10'd0, 2'd2}},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b1, '{1'b0, 2'd0, 10'd0, 2'd3}},
    '{ROW_SAMPLE, '0, '0, 10'd1022, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'h2AA, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'h155, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd1, 1'b0, '0},
    // shorten channel two mid-block so its sum overflows the mean
    '{ROW_CFG, REG_LEN_CH2, 8'd1, '0, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd5, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd7, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd1023, 1'b1, '{1'b1, 2'd2, 10'd1023, 2'd3}},
    '{ROW_SAMPLE, '0, '0, 10'd3, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd512, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd256, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd768, 1'b0, '0},
    '{ROW_SAMPLE, '0, '0, 10'd1000, 1'b0, '0}
  };

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              cfg_we_i      = 1'b0;
  rrba_pkg::ch_t                     cfg_idx_i     = '0;
  rrba_pkg::len_t                    cfg_data_i    = '0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [rrba_pkg::S_TDATA_BITS-1:0] s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [rrba_pkg::M_TDATA_BITS-1:0] m_axis_tdata;

  round_robin_block_averager u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Averager state mirrored in the testbench
  rrba_pkg::ch_t  sel_ch;
  rrba_pkg::sum_t acc_sum [rrba_pkg::NUM_CHANNELS];
  rrba_pkg::len_t acc_cnt [rrba_pkg::NUM_CHANNELS];
  rrba_pkg::len_t blk_len [rrba_pkg::NUM_CHANNELS];

  mean_beat_t pending_means [$];

  int  err_count   = 0;
  int  samples_in  = 0;
  int  means_seen  = 0;
  int  blocks_seen = 0;
  int  full_scale  = 0;
  int  cfg_writes  = 0;
  int  quiet_cycles = 0;
  bit  no_gaps     = 1'b0;
  bit  hold_done   = 1'b0;

  // Accumulate one sample and close the block when its length is reached
  function automatic mean_beat_t average_sample(input rrba_pkg::sample_t smp);
    mean_beat_t     res;
    rrba_pkg::len_t divisor;
    rrba_pkg::sum_t quot;
    res     = '0;
    divisor = (blk_len[sel_ch] == '0) ? rrba_pkg::len_t'(1) : blk_len[sel_ch];
    acc_sum[sel_ch] = acc_sum[sel_ch] + rrba_pkg::sum_t'(smp);
    acc_cnt[sel_ch] = acc_cnt[sel_ch] + rrba_pkg::len_t'(1);
    if (acc_cnt[sel_ch] >= divisor) begin
      quot      = acc_sum[sel_ch] / rrba_pkg::sum_t'(divisor);
      res.valid = 1'b1;
      res.chan  = sel_ch;
      res.mean  = (quot > rrba_pkg::sum_t'(rrba_pkg::SAMPLE_MAX)) ?
                  rrba_pkg::SAMPLE_MAX : rrba_pkg::sample_t'(quot);
      acc_sum[sel_ch] = '0;
      acc_cnt[sel_ch] = '0;
    end
    sel_ch   = (sel_ch == rrba_pkg::ch_t'(rrba_pkg::NUM_CHANNELS - 1)) ?
               '0 : sel_ch + rrba_pkg::ch_t'(1);
    res.next = sel_ch;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input mean_beat_t got,
                                 input mean_beat_t exp);
    err_count++;
    if (err_count <= MAX_PRINTS) begin
      $display({"%0t ERROR %s: got v=%0d ch=%0d mean=%0d next=%0d,",
                " exp v=%0d ch=%0d mean=%0d next=%0d"},
               $time, what, got.valid, got.chan, got.mean, got.next,
               exp.valid, exp.chan, exp.mean, exp.next);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rrba_pkg::sample_t pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return rrba_pkg::SAMPLE_MAX;
    return rrba_pkg::sample_t'($urandom_range(0, 1023));
  endfunction

  // Mostly short blocks so results come often; extremes now and then
  function automatic rrba_pkg::len_t pick_len(input int ph);
    int r;
    if (ph == 0) return rrba_pkg::len_t'(255);
    if (ph == 1) return rrba_pkg::len_t'(1);
    if (ph == 2) return '0;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return rrba_pkg::len_t'(255);
    if (r == 2) return rrba_pkg::len_t'(1);
    if (r < 5) return rrba_pkg::len_t'($urandom_range(0, 255));
    return rrba_pkg::len_t'($urandom_range(1, 8));
  endfunction

  task automatic write_len(input rrba_pkg::ch_t idx, input rrba_pkg::len_t val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    blk_len[idx] = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one sample beat and record its expected result on accept
  task automatic send_sample(input rrba_pkg::sample_t smp, input logic typed,
                             input mean_beat_t exp);
    int         gap;
    mean_beat_t pred;
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rrba_pkg::S_TDATA_BITS'(smp);
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    pred = average_sample(smp);
    pending_means.push_back(typed ? exp : pred);
    samples_in++;
  endtask

  // Let every outstanding result drain before touching the registers
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Output side: random stalls plus one long hold-off
  initial begin : result_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && means_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        end
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    mean_beat_t got;
    mean_beat_t exp;
    string      bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.valid = m_axis_tdata[rrba_pkg::POS_VALID];
      got.chan  = m_axis_tdata[rrba_pkg::POS_MCH +: rrba_pkg::CH_BITS];
      got.mean  = m_axis_tdata[rrba_pkg::POS_MEAN +: rrba_pkg::SAMPLE_BITS];
      got.next  = m_axis_tdata[rrba_pkg::POS_NEXT +: rrba_pkg::CH_BITS];
      means_seen++;
      if (pending_means.size() == 0) begin
        report_mismatch("result with no sample pending", got, '0);
      end else begin
        exp = pending_means.pop_front();
        bad = "";
        if (got.valid !== exp.valid) bad = {bad, " mean_valid"};
        if (got.chan !== exp.chan) bad = {bad, " mean_channel"};
        if (got.mean !== exp.mean) bad = {bad, " mean"};
        if (got.next !== exp.next) bad = {bad, " next_channel"};
        if (bad != "") report_mismatch({"field mismatch:", bad}, got, exp);
        if (exp.valid) begin
          blocks_seen++;
          if (exp.mean == rrba_pkg::SAMPLE_MAX) full_scale++;
        end
      end
    end
  end

  // End the run if the handshakes stop moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles, %0d results pending",
                 QUIET_LIMIT, pending_means.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin : stimulus
    mean_beat_t left;
    sel_ch = '0;
    for (int i = 0; i < rrba_pkg::NUM_CHANNELS; i++) begin
      acc_sum[i] = '0;
      acc_cnt[i] = '0;
      blk_len[i] = rrba_pkg::LEN_RESET;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_len(dir_rows[i].reg_idx, dir_rows[i].len_val);
      end else begin
        send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].exp);
      end
    end

    // Random phases, each with fresh block lengths
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      no_gaps = (ph % 4 == 3);
      for (int c = 0; c < rrba_pkg::NUM_CHANNELS; c++) begin
        write_len(rrba_pkg::ch_t'(c), pick_len(ph));
      end
      for (int k = 0; k < SAMPLES_PER_PH; k++) begin
        send_sample(pick_sample(), 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    // Wrap up
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending_means.size() != 0) begin
      left = pending_means.pop_front();
      report_mismatch("expected result never came", '0, left);
    end

    $display("Run covered %0d samples, %0d results, %0d closed blocks (%0d at full scale)",
             samples_in, means_seen, blocks_seen, full_scale);
    $display("over %0d length writes incl. 0, 1 and 255, with one %0d-cycle output stall",
             cfg_writes, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", err_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
